// ===== src/bgss_pkg.sv =====
// Shared types, constants and saturation helpers for the biquad gain / energy block.
package bgss_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 27;
	localparam int DELAY_BITS     = 40;
	localparam int ENERGY_BITS    = 62;
	localparam int ACC_BITS       = 76;
	localparam int MUL_STEPS      = COEF_BITS;
	localparam int STEP_BITS      = $clog2(MUL_STEPS);
	localparam int CFG_IDX_BITS   = 3;
	localparam int SHIFT_BITS     = ACC_BITS - COEF_FRAC_BITS;
	localparam int SQUARE_BITS    = 2 * SAMPLE_BITS;

	typedef logic signed [ACC_BITS-1:0]    acc_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [DELAY_BITS-1:0]  delay_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ENERGY_BITS-1:0]        energy_t;
	typedef logic [SQUARE_BITS-1:0]        square_t;

	localparam acc_t    ROUND_HALF  = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam coef_t   GAIN_RESET  = COEF_BITS'(1) << COEF_FRAC_BITS;
	localparam energy_t ENERGY_MAX  = '1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_B1   = 3'd0,
		CFG_B2   = 3'd1,
		CFG_A1   = 3'd2,
		CFG_A2   = 3'd3,
		CFG_GAIN = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A1,
		ST_A2,
		ST_WN,
		ST_B1,
		ST_B2,
		ST_VS,
		ST_G,
		ST_YS,
		ST_SQ,
		ST_EN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
	} mac_ctl_t;

	typedef struct packed {
		logic add;
		logic clear;
	} energy_ctl_t;

	// drop the fraction bits (rounding offset already in acc), clamp to the delay range
	function automatic delay_t sat_delay(acc_t a);
		logic [SHIFT_BITS-1:0] t;
		t = a[ACC_BITS-1:COEF_FRAC_BITS];
		if (&t[SHIFT_BITS-1:DELAY_BITS-1] || ~|t[SHIFT_BITS-1:DELAY_BITS-1])
			return delay_t'(t[DELAY_BITS-1:0]);
		else if (t[SHIFT_BITS-1])
			return delay_t'({1'b1, {(DELAY_BITS-1){1'b0}}});
		else
			return delay_t'({1'b0, {(DELAY_BITS-1){1'b1}}});
	endfunction

	function automatic sample_t sat_sample(acc_t a);
		logic [SHIFT_BITS-1:0] t;
		t = a[ACC_BITS-1:COEF_FRAC_BITS];
		if (&t[SHIFT_BITS-1:SAMPLE_BITS-1] || ~|t[SHIFT_BITS-1:SAMPLE_BITS-1])
			return sample_t'(t[SAMPLE_BITS-1:0]);
		else if (t[SHIFT_BITS-1])
			return sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});
		else
			return sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	endfunction

endpackage

// ===== src/bgss_if.sv =====
// Valid/ready stream interfaces for the sample input and result output channels.
interface bgss_in_if;
	logic              valid;
	logic              ready;
	bgss_pkg::sample_t sample_in;
	logic              block_end;

	modport source(output valid, output sample_in, output block_end, input ready);
	modport sink(input valid, input sample_in, input block_end, output ready);
endinterface

interface bgss_out_if;
	logic              valid;
	logic              ready;
	bgss_pkg::sample_t sample_out;
	bgss_pkg::energy_t block_energy;
	logic              energy_valid;

	modport source(output valid, output sample_out, output block_energy,
		output energy_valid, input ready);
	modport sink(input valid, input sample_out, input block_energy,
		input energy_valid, output ready);
endinterface

// ===== src/bgss_mac.sv =====
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle into a wide accumulator.
module bgss_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  bgss_pkg::mac_ctl_t ctl,
	input  bgss_pkg::acc_t     init,
	input  bgss_pkg::coef_t    mplier,
	input  bgss_pkg::delay_t   mcand,
	output bgss_pkg::acc_t     acc,
	output logic               last
);

	logic                           run_q;
	logic [bgss_pkg::STEP_BITS-1:0] cnt_q;
	bgss_pkg::coef_t                mplier_q;
	bgss_pkg::acc_t                 mcand_q;
	bgss_pkg::acc_t                 acc_q;

	assign last = run_q && (cnt_q == bgss_pkg::STEP_BITS'(bgss_pkg::MUL_STEPS - 1));
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (last) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// top multiplier bit carries negative weight
	always_ff @(posedge clk) begin
		if (ctl.load)
			acc_q <= init;
		else if (run_q && mplier_q[0])
			acc_q <= last ? acc_q - mcand_q : acc_q + mcand_q;

		if (ctl.start) begin
			mplier_q <= mplier;
			mcand_q  <= bgss_pkg::acc_t'(mcand);
		end else if (run_q) begin
			mplier_q <= mplier_q >>> 1;
			mcand_q  <= mcand_q <<< 1;
		end
	end

endmodule

// ===== src/bgss_energy.sv =====
// Saturating block energy accumulator with clear on block close.
module bgss_energy (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bgss_pkg::energy_ctl_t ctl,
	input  bgss_pkg::square_t     square,
	output bgss_pkg::energy_t     total
);

	bgss_pkg::energy_t            energy_q;
	logic [bgss_pkg::ENERGY_BITS:0] sum;

	assign sum   = {1'b0, energy_q} + (bgss_pkg::ENERGY_BITS + 1)'(square);
	assign total = energy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			energy_q <= '0;
		else if (ctl.clear)
			energy_q <= '0;
		else if (ctl.add)
			energy_q <= sum[bgss_pkg::ENERGY_BITS] ? bgss_pkg::ENERGY_MAX
				: sum[bgss_pkg::ENERGY_BITS-1:0];
	end

endmodule

// ===== src/biquad_gain_sum_squares.sv =====
// Top level: one direct form II biquad section (b0 = 1) with output gain and block energy.
//
// One sample is taken at a time. Every product goes through a single bit-serial
// shift-add multiplier that handles one multiplier bit per cycle; a sample needs six
// products (a1*w0, a2*w1, b1*w0, b2*w1, gain*v and y*y) plus the sequencing states
// WN, VS, YS, EN and FIN. The next input is taken once the block is back in idle,
// which it reaches from FIN when the result is loaded into the output register; a
// result waits in the output register while the next sample is already being taken.
// Coefficients are written through the cfg port (index 0..4: b1, b2, a1, a2, gain);
// the user writes them only while no sample is in flight; the block does not enforce it.
module biquad_gain_sum_squares (
	input  logic                              clk,
	input  logic                              arst_n,
	bgss_in_if.sink                           in_ch,
	bgss_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [bgss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bgss_pkg::COEF_BITS-1:0]    cfg_data
);

	bgss_pkg::state_t      state_q, state_d;
	bgss_pkg::coef_t       coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q, out_gain_q;
	bgss_pkg::delay_t      delay_first_q, delay_second_q, wnew_q;
	bgss_pkg::sample_t     y_q;
	logic                  last_q;

	logic                  out_valid_q;
	bgss_pkg::sample_t     sample_out_q;
	bgss_pkg::energy_t     block_energy_q;
	logic                  energy_valid_q;

	bgss_pkg::mac_ctl_t    mac_ctl;
	bgss_pkg::acc_t        mac_init, mac_acc;
	bgss_pkg::coef_t       mac_mplier;
	bgss_pkg::delay_t      mac_mcand;
	logic                  mac_last;
	bgss_pkg::energy_ctl_t en_ctl;
	bgss_pkg::energy_t     energy_total;
	bgss_pkg::delay_t      acc_delay;
	bgss_pkg::sample_t     acc_sample;
	logic                  in_xfer, wnew_en, y_en, delay_en, out_load;

	assign in_ch.ready       = (state_q == bgss_pkg::ST_IDLE);
	assign in_xfer           = in_ch.valid && in_ch.ready;
	assign acc_delay         = bgss_pkg::sat_delay(mac_acc);
	assign acc_sample        = bgss_pkg::sat_sample(mac_acc);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_out   = sample_out_q;
	assign out_ch.block_energy = block_energy_q;
	assign out_ch.energy_valid = energy_valid_q;

	bgss_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.init   (mac_init),
		.mplier (mac_mplier),
		.mcand  (mac_mcand),
		.acc    (mac_acc),
		.last   (mac_last)
	);

	bgss_energy u_energy (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (en_ctl),
		.square (mac_acc[bgss_pkg::SQUARE_BITS-1:0]),
		.total  (energy_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mac_ctl    = '0;
		mac_init   = bgss_pkg::ROUND_HALF;
		mac_mplier = coef_a1_q;
		mac_mcand  = delay_first_q;
		en_ctl     = '0;
		wnew_en    = 1'b0;
		y_en       = 1'b0;
		delay_en   = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			bgss_pkg::ST_IDLE: begin
				if (in_xfer) begin
					mac_ctl.load  = 1'b1;
					mac_ctl.start = 1'b1;
					mac_init = (bgss_pkg::acc_t'(in_ch.sample_in) <<< bgss_pkg::COEF_FRAC_BITS)
						+ bgss_pkg::ROUND_HALF;
					state_d = bgss_pkg::ST_A1;
				end
			end
			bgss_pkg::ST_A1: begin
				if (mac_last) begin
					mac_ctl.start = 1'b1;
					mac_mplier = coef_a2_q;
					mac_mcand  = delay_second_q;
					state_d = bgss_pkg::ST_A2;
				end
			end
			bgss_pkg::ST_A2: begin
				if (mac_last)
					state_d = bgss_pkg::ST_WN;
			end
			bgss_pkg::ST_WN: begin
				wnew_en = 1'b1;
				mac_ctl.load  = 1'b1;
				mac_ctl.start = 1'b1;
				mac_init = (bgss_pkg::acc_t'(acc_delay) <<< bgss_pkg::COEF_FRAC_BITS)
					+ bgss_pkg::ROUND_HALF;
				mac_mplier = coef_b1_q;
				state_d = bgss_pkg::ST_B1;
			end
			bgss_pkg::ST_B1: begin
				if (mac_last) begin
					mac_ctl.start = 1'b1;
					mac_mplier = coef_b2_q;
					mac_mcand  = delay_second_q;
					state_d = bgss_pkg::ST_B2;
				end
			end
			bgss_pkg::ST_B2: begin
				if (mac_last)
					state_d = bgss_pkg::ST_VS;
			end
			bgss_pkg::ST_VS: begin
				mac_ctl.load  = 1'b1;
				mac_ctl.start = 1'b1;
				mac_mplier = out_gain_q;
				mac_mcand  = acc_delay;
				state_d = bgss_pkg::ST_G;
			end
			bgss_pkg::ST_G: begin
				if (mac_last)
					state_d = bgss_pkg::ST_YS;
			end
			bgss_pkg::ST_YS: begin
				y_en = 1'b1;
				mac_ctl.load  = 1'b1;
				mac_ctl.start = 1'b1;
				mac_init   = '0;
				mac_mplier = bgss_pkg::coef_t'(acc_sample);
				mac_mcand  = bgss_pkg::delay_t'(acc_sample);
				state_d = bgss_pkg::ST_SQ;
			end
			bgss_pkg::ST_SQ: begin
				if (mac_last)
					state_d = bgss_pkg::ST_EN;
			end
			bgss_pkg::ST_EN: begin
				en_ctl.add = 1'b1;
				delay_en   = 1'b1;
				state_d = bgss_pkg::ST_FIN;
			end
			bgss_pkg::ST_FIN: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load     = 1'b1;
					en_ctl.clear = last_q;
					state_d = bgss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bgss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b1_q      <= '0;
			coef_b2_q      <= '0;
			coef_a1_q      <= '0;
			coef_a2_q      <= '0;
			out_gain_q     <= bgss_pkg::GAIN_RESET;
			delay_first_q  <= '0;
			delay_second_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (bgss_pkg::cfg_idx_t'(cfg_index))
					bgss_pkg::CFG_B1:   coef_b1_q  <= cfg_data;
					bgss_pkg::CFG_B2:   coef_b2_q  <= cfg_data;
					bgss_pkg::CFG_A1:   coef_a1_q  <= cfg_data;
					bgss_pkg::CFG_A2:   coef_a2_q  <= cfg_data;
					bgss_pkg::CFG_GAIN: out_gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (delay_en) begin
				delay_second_q <= delay_first_q;
				delay_first_q  <= wnew_q;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			last_q <= in_ch.block_end;
		if (wnew_en)
			wnew_q <= acc_delay;
		if (y_en)
			y_q <= acc_sample;
		if (out_load) begin
			sample_out_q   <= y_q;
			block_energy_q <= last_q ? energy_total : '0;
			energy_valid_q <= last_q;
		end
	end

endmodule

// ===== src/bgss_checker.sv =====
// Port-level assertions for the biquad gain / energy block, bound to its top level.
module bgss_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input bgss_pkg::sample_t sample_out,
	input bgss_pkg::energy_t block_energy,
	input logic              energy_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out) && $stable(block_energy)
			&& $stable(energy_valid))
		else $error("result changed while stalled");

	// one sample in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is in flight");

	a_energy_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !energy_valid |-> block_energy == '0)
		else $error("energy shown on a sample that does not close a block");

endmodule

bind biquad_gain_sum_squares bgss_checker u_bgss_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.sample_out   (out_ch.sample_out),
	.block_energy (out_ch.block_energy),
	.energy_valid (out_ch.energy_valid)
);
